/* src/graham_scan_convex_hull_core_macros.svh */
// Assertion macros shared by the convex hull core.
// Each macro expands to one labelled concurrent assertion on i_clk / i_rst_n.
`ifndef GRAHAM_SCAN_CONVEX_HULL_CORE_MACROS_SVH
`define GRAHAM_SCAN_CONVEX_HULL_CORE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define GHULL_AST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define GHULL_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ghull_pkg.sv */
// Shared types and constants for the convex hull core.
// No dependencies.
`timescale 1ns / 1ps

package ghull_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_BITS     = 16;

    typedef enum logic [4:0] {
        S_LOAD, S_PIV_RD, S_PIV_UPD,
        S_SRT_INIT, S_SRT_NEXT, S_SRT_LDB, S_SRT_CHK, S_SRT_ORD, S_SRT_LDC, S_SRT_CMP,
        S_SCN_NEXT, S_SCN_ORD, S_SCN_LDC, S_SCN_CHK, S_SCN_S2, S_SCN_LDA, S_SCN_LDB,
        S_SCN_CMP,
        S_EMT_RD, S_EMT_PT, S_EMT_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE, PH_DIFF, PH_CROSS, PH_SQB, PH_SQC, PH_DIST, PH_DONE
    } t_cmp_ph;

    // point memory read address source
    typedef enum logic [1:0] {PT_IDX, PT_ORD, PT_STK} t_pt_sel;

    // order memory write data source
    typedef enum logic [1:0] {OW_IDX, OW_ORD, OW_PIV} t_ow_sel;

    typedef struct packed {
        logic    pt_we;
        logic    pt_re;
        t_pt_sel pt_sel;
        logic    piv_upd;
        logic    piv_init;
        logic    ord_we;
        t_ow_sel ow_sel;
        logic    ord_re;
        logic    stk_we;
        logic    stk_re;
        logic    ld_a;
        logic    ld_a_piv;
        logic    ld_b;
        logic    ld_c;
        logic    cmp_start;
        logic    out_ld;
        logic    out_last;
        logic    out_drop;
    } t_dp_cmd;

    typedef struct packed {
        logic piv_hit;
        logic cmp_done;
        logic ahead;
        logic turn_neg;
        logic out_free;
    } t_dp_sts;

endpackage

/* src/ghull_if.sv */
// Valid/ready channel interfaces for points in and hull vertices out.
// Depends on ghull_pkg for the field width.
`timescale 1ns / 1ps

interface ghull_pt_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ghull_pkg::FIELD_BITS-1:0] point_x;
    logic signed [ghull_pkg::FIELD_BITS-1:0] point_y;
    logic                                   last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface ghull_hull_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ghull_pkg::FIELD_BITS-1:0] hull_x;
    logic signed [ghull_pkg::FIELD_BITS-1:0] hull_y;
    logic                                   hull_last;
    logic                                   points_dropped;

    modport source (output valid, hull_x, hull_y, hull_last, points_dropped, input ready);
    modport sink   (input valid, hull_x, hull_y, hull_last, points_dropped, output ready);
endinterface

/* src/ghull_dp.sv */
// Datapath: point, order and stack memories, pivot and operand registers,
// the shared cross/distance compare unit and the output register. Uses ghull_pkg.
`timescale 1ns / 1ps

module ghull_dp #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ghull_pkg::t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]           i_idx,
    input  logic [$clog2(MAX_POINTS)-1:0]           i_pt_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0]           i_ord_raddr,
    input  logic [$clog2(MAX_POINTS)-1:0]           i_ord_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0]           i_stk_raddr,
    input  logic [$clog2(MAX_POINTS)-1:0]           i_stk_waddr,
    input  logic signed [ghull_pkg::FIELD_BITS-1:0] i_pt_x,
    input  logic signed [ghull_pkg::FIELD_BITS-1:0] i_pt_y,
    input  logic                                    i_out_ready,
    output ghull_pkg::t_dp_sts                      o_sts,
    output logic                                    o_out_valid,
    output logic signed [ghull_pkg::FIELD_BITS-1:0] o_hull_x,
    output logic signed [ghull_pkg::FIELD_BITS-1:0] o_hull_y,
    output logic                                    o_hull_last,
    output logic                                    o_hull_drop
);
    import ghull_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic [2*CB-1:0] r_pt_mem [MAX_POINTS];
    logic [AW-1:0]   r_ord_mem [MAX_POINTS];
    logic [AW-1:0]   r_stk_mem [MAX_POINTS];

    logic [2*CB-1:0] r_pt_rd;
    logic [AW-1:0]   r_ord_rd;
    logic [AW-1:0]   r_stk_rd;

    logic [AW-1:0]   w_pt_raddr;
    logic [AW-1:0]   w_ord_wdata;
    logic [CB-1:0]   w_in_x;
    logic [CB-1:0]   w_in_y;
    logic signed [CB-1:0] w_rd_x;
    logic signed [CB-1:0] w_rd_y;

    logic signed [CB-1:0] r_piv_x, r_piv_y;
    logic [AW-1:0]        r_piv_idx;
    logic signed [CB-1:0] r_a_x, r_a_y, r_b_x, r_b_y, r_c_x, r_c_y;

    t_cmp_ph              r_ph;
    logic signed [DW-1:0] r_dbx, r_dby, r_dcx, r_dcy;
    logic signed [DW-1:0] w_ma0, w_mb0, w_ma1, w_mb1;
    logic signed [PW-1:0] r_m0, r_m1;
    logic signed [XW-1:0] r_cross;
    logic [XW-1:0]        r_db2, r_dc2;

    logic                             r_out_valid;
    logic signed [FIELD_BITS-1:0]     r_out_x, r_out_y;
    logic                             r_out_last, r_out_drop;
    logic                             w_out_free;

    // input coordinates are taken as COORD_BITS-bit two's complement
    assign w_in_x = CB'($unsigned(i_pt_x));
    assign w_in_y = CB'($unsigned(i_pt_y));
    assign w_rd_x = r_pt_rd[2*CB-1:CB];
    assign w_rd_y = r_pt_rd[CB-1:0];

    always_comb begin
        case (i_cmd.pt_sel)
            PT_ORD:  w_pt_raddr = r_ord_rd;
            PT_STK:  w_pt_raddr = r_stk_rd;
            default: w_pt_raddr = i_idx;
        endcase
        case (i_cmd.ow_sel)
            OW_ORD:  w_ord_wdata = r_ord_rd;
            OW_PIV:  w_ord_wdata = r_piv_idx;
            default: w_ord_wdata = i_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_we) begin
            r_pt_mem[i_pt_waddr] <= {w_in_x, w_in_y};
        end
        if (i_cmd.pt_re) begin
            r_pt_rd <= r_pt_mem[w_pt_raddr];
        end
        if (i_cmd.ord_we) begin
            r_ord_mem[i_ord_waddr] <= w_ord_wdata;
        end
        if (i_cmd.ord_re) begin
            r_ord_rd <= r_ord_mem[i_ord_raddr];
        end
        if (i_cmd.stk_we) begin
            r_stk_mem[i_stk_waddr] <= r_ord_rd;
        end
        if (i_cmd.stk_re) begin
            r_stk_rd <= r_stk_mem[i_stk_raddr];
        end
    end

    // pivot tracking and operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.piv_upd && (i_cmd.piv_init || (w_rd_y < r_piv_y) ||
                              ((w_rd_y == r_piv_y) && (w_rd_x < r_piv_x)))) begin
            r_piv_x   <= w_rd_x;
            r_piv_y   <= w_rd_y;
            r_piv_idx <= i_idx;
        end
        if (i_cmd.ld_a_piv) begin
            r_a_x <= r_piv_x;
            r_a_y <= r_piv_y;
        end else if (i_cmd.ld_a) begin
            r_a_x <= w_rd_x;
            r_a_y <= w_rd_y;
        end
        if (i_cmd.ld_b) begin
            r_b_x <= w_rd_x;
            r_b_y <= w_rd_y;
        end
        if (i_cmd.ld_c) begin
            r_c_x <= w_rd_x;
            r_c_y <= w_rd_y;
        end
    end

    // compare unit: one multiplier pair, reused for the cross product and both distances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else begin
            unique case (r_ph)
                PH_IDLE:  r_ph <= i_cmd.cmp_start ? PH_DIFF : PH_IDLE;
                PH_DIFF:  r_ph <= PH_CROSS;
                PH_CROSS: r_ph <= PH_SQB;
                PH_SQB:   r_ph <= PH_SQC;
                PH_SQC:   r_ph <= PH_DIST;
                PH_DIST:  r_ph <= PH_DONE;
                default:  r_ph <= PH_IDLE;
            endcase
        end
    end

    always_comb begin
        case (r_ph)
            PH_CROSS: begin
                w_ma0 = r_dbx; w_mb0 = r_dcy; w_ma1 = r_dby; w_mb1 = r_dcx;
            end
            PH_SQB: begin
                w_ma0 = r_dbx; w_mb0 = r_dbx; w_ma1 = r_dby; w_mb1 = r_dby;
            end
            default: begin
                w_ma0 = r_dcx; w_mb0 = r_dcx; w_ma1 = r_dcy; w_mb1 = r_dcy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_m0 <= PW'(w_ma0) * PW'(w_mb0);
        r_m1 <= PW'(w_ma1) * PW'(w_mb1);
        if (r_ph == PH_DIFF) begin
            r_dbx <= DW'(r_b_x) - DW'(r_a_x);
            r_dby <= DW'(r_b_y) - DW'(r_a_y);
            r_dcx <= DW'(r_c_x) - DW'(r_a_x);
            r_dcy <= DW'(r_c_y) - DW'(r_a_y);
        end
        if (r_ph == PH_SQB) begin
            r_cross <= XW'(r_m0) - XW'(r_m1);
        end
        if (r_ph == PH_SQC) begin
            r_db2 <= XW'($unsigned(r_m0)) + XW'($unsigned(r_m1));
        end
        if (r_ph == PH_DIST) begin
            r_dc2 <= XW'($unsigned(r_m0)) + XW'($unsigned(r_m1));
        end
    end

    // output register, refilled as soon as the held beat is taken
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_x    <= FIELD_BITS'(w_rd_x);
            r_out_y    <= FIELD_BITS'(w_rd_y);
            r_out_last <= i_cmd.out_last;
            r_out_drop <= i_cmd.out_drop;
        end
    end

    assign o_sts.piv_hit  = (i_idx == r_piv_idx);
    assign o_sts.cmp_done = (r_ph == PH_DONE);
    assign o_sts.ahead    = (!r_cross[XW-1] && (r_cross != '0)) ||
                            ((r_cross == '0) && (r_db2 < r_dc2));
    assign o_sts.turn_neg = r_cross[XW-1];
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_hull_x    = r_out_x;
    assign o_hull_y    = r_out_y;
    assign o_hull_last = r_out_last;
    assign o_hull_drop = r_out_drop;

endmodule

/* src/ghull_ctrl.sv */
// Controller: sequences loading, pivot search, insertion sort, stack scan and emit.
// Uses ghull_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "graham_scan_convex_hull_core_macros.svh"

module ghull_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_last,
    output logic                          o_in_ready,
    input  ghull_pkg::t_dp_sts            i_sts,
    output ghull_pkg::t_dp_cmd            o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_idx,
    output logic [$clog2(MAX_POINTS)-1:0] o_pt_waddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_ord_raddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_ord_waddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_stk_raddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_stk_waddr
);
    import ghull_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_i, n_i, r_k, n_k, r_pos, n_pos, r_sp, n_sp;
    logic [CW-1:0] w_pos_m1, w_sp_m1, w_sp_m2;

    assign w_pos_m1 = r_pos - ONE;
    assign w_sp_m1  = r_sp - ONE;
    assign w_sp_m2  = r_sp - TWO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_k     <= '0;
            r_pos   <= '0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_sp    <= n_sp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_i        = r_i;
        n_k        = r_k;
        n_pos      = r_pos;
        n_sp       = r_sp;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        o_idx       = r_i[AW-1:0];
        o_pt_waddr  = r_cnt[AW-1:0];
        o_ord_raddr = (r_state == S_SRT_CHK) ? w_pos_m1[AW-1:0] : r_i[AW-1:0];
        o_ord_waddr = (r_state == S_SRT_INIT) ? '0 : r_pos[AW-1:0];
        o_stk_waddr = r_sp[AW-1:0];
        if (r_state == S_SCN_CHK) begin
            o_stk_raddr = w_sp_m2[AW-1:0];
        end else if (r_state == S_SCN_S2) begin
            o_stk_raddr = w_sp_m1[AW-1:0];
        end else begin
            o_stk_raddr = r_k[AW-1:0];
        end

        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // store while room is left, otherwise drop and flag
                    if (r_cnt < FULL) begin
                        o_cmd.pt_we = 1'b1;
                        n_cnt       = r_cnt + ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_i     = '0;
                        n_state = S_PIV_RD;
                    end
                end
            end
            S_PIV_RD: begin
                o_cmd.pt_re  = 1'b1;
                o_cmd.pt_sel = PT_IDX;
                n_state      = S_PIV_UPD;
            end
            S_PIV_UPD: begin
                o_cmd.piv_upd  = 1'b1;
                o_cmd.piv_init = (r_i == '0);
                if (r_i + ONE == r_cnt) begin
                    n_state = S_SRT_INIT;
                end else begin
                    n_i     = r_i + ONE;
                    n_state = S_PIV_RD;
                end
            end
            S_SRT_INIT: begin
                o_cmd.ord_we = 1'b1;
                o_cmd.ow_sel = OW_PIV;
                n_i          = '0;
                n_k          = ONE;
                n_state      = S_SRT_NEXT;
            end
            S_SRT_NEXT: begin
                if (r_i == r_cnt) begin
                    n_i     = '0;
                    n_sp    = '0;
                    n_state = S_SCN_NEXT;
                end else if (i_sts.piv_hit) begin
                    n_i = r_i + ONE;
                end else begin
                    o_cmd.pt_re  = 1'b1;
                    o_cmd.pt_sel = PT_IDX;
                    n_state      = S_SRT_LDB;
                end
            end
            S_SRT_LDB: begin
                o_cmd.ld_b     = 1'b1;
                o_cmd.ld_a_piv = 1'b1;
                n_pos          = r_k;
                n_state        = S_SRT_CHK;
            end
            S_SRT_CHK: begin
                if (r_pos > ONE) begin
                    o_cmd.ord_re = 1'b1;
                    n_state      = S_SRT_ORD;
                end else begin
                    o_cmd.ord_we = 1'b1;
                    o_cmd.ow_sel = OW_IDX;
                    n_k          = r_k + ONE;
                    n_i          = r_i + ONE;
                    n_state      = S_SRT_NEXT;
                end
            end
            S_SRT_ORD: begin
                o_cmd.pt_re  = 1'b1;
                o_cmd.pt_sel = PT_ORD;
                n_state      = S_SRT_LDC;
            end
            S_SRT_LDC: begin
                o_cmd.ld_c      = 1'b1;
                o_cmd.cmp_start = 1'b1;
                n_state         = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                if (i_sts.cmp_done) begin
                    o_cmd.ord_we = 1'b1;
                    if (i_sts.ahead) begin
                        // shift the later entry up one place
                        o_cmd.ow_sel = OW_ORD;
                        n_pos        = w_pos_m1;
                        n_state      = S_SRT_CHK;
                    end else begin
                        o_cmd.ow_sel = OW_IDX;
                        n_k          = r_k + ONE;
                        n_i          = r_i + ONE;
                        n_state      = S_SRT_NEXT;
                    end
                end
            end
            S_SCN_NEXT: begin
                if (r_i == r_cnt) begin
                    n_k     = '0;
                    n_state = S_EMT_RD;
                end else begin
                    o_cmd.ord_re = 1'b1;
                    n_state      = S_SCN_ORD;
                end
            end
            S_SCN_ORD: begin
                o_cmd.pt_re  = 1'b1;
                o_cmd.pt_sel = PT_ORD;
                n_state      = S_SCN_LDC;
            end
            S_SCN_LDC: begin
                o_cmd.ld_c = 1'b1;
                n_state    = S_SCN_CHK;
            end
            S_SCN_CHK: begin
                if (r_sp >= TWO) begin
                    o_cmd.stk_re = 1'b1;
                    n_state      = S_SCN_S2;
                end else begin
                    o_cmd.stk_we = 1'b1;
                    n_sp         = r_sp + ONE;
                    n_i          = r_i + ONE;
                    n_state      = S_SCN_NEXT;
                end
            end
            S_SCN_S2: begin
                o_cmd.pt_re  = 1'b1;
                o_cmd.pt_sel = PT_STK;
                o_cmd.stk_re = 1'b1;
                n_state      = S_SCN_LDA;
            end
            S_SCN_LDA: begin
                o_cmd.ld_a   = 1'b1;
                o_cmd.pt_re  = 1'b1;
                o_cmd.pt_sel = PT_STK;
                n_state      = S_SCN_LDB;
            end
            S_SCN_LDB: begin
                o_cmd.ld_b      = 1'b1;
                o_cmd.cmp_start = 1'b1;
                n_state         = S_SCN_CMP;
            end
            S_SCN_CMP: begin
                if (i_sts.cmp_done) begin
                    if (i_sts.turn_neg) begin
                        // strict clockwise turn: pop and test again
                        n_sp    = w_sp_m1;
                        n_state = S_SCN_CHK;
                    end else begin
                        o_cmd.stk_we = 1'b1;
                        n_sp         = r_sp + ONE;
                        n_i          = r_i + ONE;
                        n_state      = S_SCN_NEXT;
                    end
                end
            end
            S_EMT_RD: begin
                if (r_k == r_sp) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_sp    = '0;
                    n_state = S_LOAD;
                end else begin
                    o_cmd.stk_re = 1'b1;
                    n_state      = S_EMT_PT;
                end
            end
            S_EMT_PT: begin
                o_cmd.pt_re  = 1'b1;
                o_cmd.pt_sel = PT_STK;
                n_state      = S_EMT_OUT;
            end
            S_EMT_OUT: begin
                // hold the vertex until the output register can take it
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_last = (r_k + ONE == r_sp);
                    o_cmd.out_drop = r_ovf;
                    n_k            = r_k + ONE;
                    n_state        = S_EMT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    `GHULL_AST(a_sp_le_cnt, (r_sp <= r_cnt), "hull stack deeper than point count")
    `GHULL_AST(a_sort_pos, (r_state == S_SRT_CMP) |-> (r_pos >= TWO), "sort compare at bottom")
    `GHULL_AST_NXT(a_ovf_set, (r_state == S_LOAD && i_in_valid && r_cnt == FULL), (r_ovf), "overflow not flagged")

endmodule

/* src/graham_scan_convex_hull_core.sv */
// Points load at one beat per cycle; the last point starts the hull run, during which
// no point is taken. Run: pivot search, then insertion sort (worst case n*n/2 compares),
// then the stack scan by turn tests, then emit, which waits on output back-pressure.
// Rate is set by the single-read point memory and the one shared two-multiplier
// compare unit. Synchronous active-low reset empties the store.
`timescale 1ns / 1ps

module graham_scan_convex_hull_core #(
    parameter int MAX_POINTS = ghull_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = ghull_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ghull_pt_if.sink    i_pt,
    ghull_hull_if.source o_hull
);
    import ghull_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic          w_in_ready;
    logic [AW-1:0] w_idx, w_pt_waddr, w_ord_raddr, w_ord_waddr, w_stk_raddr, w_stk_waddr;

    ghull_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .i_in_last   (i_pt.last_point),
        .o_in_ready  (w_in_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx),
        .o_pt_waddr  (w_pt_waddr),
        .o_ord_raddr (w_ord_raddr),
        .o_ord_waddr (w_ord_waddr),
        .o_stk_raddr (w_stk_raddr),
        .o_stk_waddr (w_stk_waddr)
    );

    ghull_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .i_pt_waddr  (w_pt_waddr),
        .i_ord_raddr (w_ord_raddr),
        .i_ord_waddr (w_ord_waddr),
        .i_stk_raddr (w_stk_raddr),
        .i_stk_waddr (w_stk_waddr),
        .i_pt_x      (i_pt.point_x),
        .i_pt_y      (i_pt.point_y),
        .i_out_ready (o_hull.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_hull.valid),
        .o_hull_x    (o_hull.hull_x),
        .o_hull_y    (o_hull.hull_y),
        .o_hull_last (o_hull.hull_last),
        .o_hull_drop (o_hull.points_dropped)
    );

    assign i_pt.ready = w_in_ready;

endmodule
